[src/fhas_pkg.sv]
// shared constants, tap table and control type for the hilbert analytic signal block
package fhas_pkg;

    localparam int FIR_LENGTH       = 31;
    localparam int HALF             = FIR_LENGTH / 2;
    localparam int NTAP             = (HALF + 1) / 2;
    localparam int FILL_W           = $clog2(HALF + 1);
    localparam int SAMPLE_WIDTH_DEF = 16;
    localparam int TAP_W            = 15;
    localparam int TAP_SUM_W        = TAP_W + $clog2(NTAP);
    localparam int ROUND_SHIFT      = 15;

    // unsigned q0.15 magnitudes of the windowed 2/(pi*k) taps for odd lags k = 1, 3, 5, ...
    localparam logic [TAP_W-1:0] TAP_MAG [NTAP] = '{
        15'd20489, 15'd5905, 15'd2628, 15'd1174,
        15'd465,   15'd146,  15'd27,   15'd0
    };

    typedef struct packed {
        logic push;
        logic zero;
        logic clear;
    } t_dl_ctrl;

endpackage

[src/fhas_delay_line.sv]
// sample history shift line with the antisymmetric tap pair differences
module fhas_delay_line import fhas_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  t_dl_ctrl                       i_ctrl,
    input  logic signed [SAMPLE_WIDTH-1:0] i_sample,
    output logic signed [SAMPLE_WIDTH-1:0] o_center,
    output logic signed [SAMPLE_WIDTH:0]   o_diff [NTAP]
);

    logic signed [SAMPLE_WIDTH-1:0] r_hist [FIR_LENGTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            for (int i = 0; i < FIR_LENGTH; i++) begin
                r_hist[i] <= '0;
            end
        end else if (i_ctrl.push) begin
            for (int i = FIR_LENGTH - 1; i > 0; i--) begin
                r_hist[i] <= r_hist[i-1];
            end
            r_hist[0] <= i_ctrl.zero ? '0 : i_sample;
        end
    end

    assign o_center = r_hist[HALF];

    always_comb begin
        for (int i = 0; i < NTAP; i++) begin
            o_diff[i] = (SAMPLE_WIDTH + 1)'(r_hist[HALF + 2 * i + 1])
                      - (SAMPLE_WIDTH + 1)'(r_hist[HALF - 2 * i - 1]);
        end
    end

endmodule

[src/fhas_da_mac.sv]
// bit-serial distributed arithmetic accumulator over the tap differences, msb first
module fhas_da_mac import fhas_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int ACC_W        = SAMPLE_WIDTH + TAP_SUM_W + 2
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [SAMPLE_WIDTH:0] i_diff [NTAP],
    output logic                     o_done,
    output logic signed [ACC_W-1:0]  o_acc
);

    localparam int DW    = SAMPLE_WIDTH + 1;
    localparam int CNT_W = $clog2(DW);

    logic        [DW-1:0]        r_sh [NTAP];
    logic signed [ACC_W-1:0]     r_acc;
    logic        [CNT_W-1:0]     r_cnt;
    logic                        r_busy;
    logic                        r_first;
    logic                        r_done;
    logic        [TAP_SUM_W-1:0] s_sum;
    logic signed [ACC_W-1:0]     s_term;
    logic signed [ACC_W-1:0]     n_acc;

    // sum of the taps whose difference has a one in the current bit
    always_comb begin
        s_sum = '0;
        for (int i = 0; i < NTAP; i++) begin
            if (r_sh[i][DW-1]) begin
                s_sum = s_sum + TAP_SUM_W'(TAP_MAG[i]);
            end
        end
        s_term = $signed({{(ACC_W - TAP_SUM_W){1'b0}}, s_sum});
        n_acc  = r_first ? -s_term : (r_acc <<< 1) + s_term;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_first <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                for (int i = 0; i < NTAP; i++) begin
                    r_sh[i] <= i_diff[i];
                end
                r_cnt   <= CNT_W'(DW - 1);
                r_busy  <= 1'b1;
                r_first <= 1'b1;
            end else if (r_busy) begin
                for (int i = 0; i < NTAP; i++) begin
                    r_sh[i] <= {r_sh[i][DW-2:0], 1'b0};
                end
                r_acc   <= n_acc;
                r_first <= 1'b0;
                r_cnt   <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;

endmodule

[src/fir_hilbert_analytic_signal.sv]
// top level of the streaming fir hilbert transformer giving the analytic signal
//
// Each input item is one signed sample with tlast marking the final sample of a
// signal. Once half the filter length of samples has been seen, every item gives
// one result: the sample delayed by half the length as the real part and the
// Blackman-windowed Hilbert filter output, rounded and saturated, as the
// imaginary part. An item with tlast flushes the pending results with zero
// padding, ends the run with tlast on the output, and clears the history, so a
// signal of n items yields n results. The filter output comes from a bit-serial
// accumulator that takes one bit of every tap difference per cycle. An item
// that gives a result holds the input not ready until its result is registered,
// an item during the start of a signal is taken at once, and a final item holds
// the input not ready until every flushed result is registered. A finished
// result waits in the output register while the next item is accepted.
module fir_hilbert_analytic_signal import fhas_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int IN_W         = 8 * ((SAMPLE_WIDTH + 7) / 8),
    parameter int OUT_W        = 8 * ((2 * SAMPLE_WIDTH + 7) / 8)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // sample
    input  logic             s_axis_tlast,
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [OUT_W-1:0] m_axis_tdata,   // real_part, imag_part
    output logic             m_axis_tlast
);

    localparam int ACC_W = SAMPLE_WIDTH + TAP_SUM_W + 2;
    localparam logic signed [ACC_W-1:0] RND    = ACC_W'(1) <<< (ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH0,
        S_LOAD,
        S_CALC,
        S_DONE
    } t_state;

    t_state                          r_state;
    logic [FILL_W-1:0]               r_fill;
    logic [FILL_W-1:0]               r_left;
    logic                            r_flush;
    logic                            r_end;
    logic                            r_m_tvalid;
    logic                            r_m_tlast;
    logic signed [SAMPLE_WIDTH-1:0]  r_real;
    logic signed [SAMPLE_WIDTH-1:0]  r_imag;

    t_dl_ctrl                        s_dl_ctrl;
    logic                            s_in_acc;
    logic                            s_slot_free;
    logic                            s_finish;
    logic signed [SAMPLE_WIDTH-1:0]  s_center;
    logic signed [SAMPLE_WIDTH:0]    s_diff [NTAP];
    logic                            s_mac_done;
    logic signed [ACC_W-1:0]         s_acc;
    logic signed [ACC_W-1:0]         s_rounded;
    logic signed [ACC_W-1:0]         s_scaled;
    logic signed [SAMPLE_WIDTH-1:0]  s_imag;

    assign s_axis_tready = (r_state == S_IDLE);
    assign s_in_acc      = s_axis_tvalid && s_axis_tready;
    assign s_slot_free   = !r_m_tvalid || m_axis_tready;
    assign s_finish      = (r_state == S_DONE) && s_slot_free && r_flush && (r_left == '0);

    assign s_dl_ctrl.push  = s_in_acc || (r_state == S_PUSH0);
    assign s_dl_ctrl.zero  = (r_state == S_PUSH0);
    assign s_dl_ctrl.clear = s_finish;

    fhas_delay_line #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_delay_line (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (s_dl_ctrl),
        .i_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
        .o_center (s_center),
        .o_diff   (s_diff)
    );

    fhas_da_mac #(
        .SAMPLE_WIDTH(SAMPLE_WIDTH),
        .ACC_W       (ACC_W)
    ) u_da_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_diff  (s_diff),
        .o_done  (s_mac_done),
        .o_acc   (s_acc)
    );

    // round half up at q15 then saturate
    always_comb begin
        s_rounded = s_acc + RND;
        s_scaled  = s_rounded >>> ROUND_SHIFT;
        if (s_scaled > SAT_HI) begin
            s_imag = SAT_HI[SAMPLE_WIDTH-1:0];
        end else if (s_scaled < SAT_LO) begin
            s_imag = SAT_LO[SAMPLE_WIDTH-1:0];
        end else begin
            s_imag = s_scaled[SAMPLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fill     <= '0;
            r_left     <= '0;
            r_flush    <= 1'b0;
            r_end      <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (m_axis_tready && r_state != S_DONE) begin
                r_m_tvalid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_in_acc) begin
                        if (r_fill == FILL_W'(HALF)) begin
                            r_end   <= 1'b0;
                            r_flush <= s_axis_tlast;
                            r_left  <= FILL_W'(HALF);
                            r_state <= S_LOAD;
                        end else begin
                            r_fill <= r_fill + 1'b1;
                            if (s_axis_tlast) begin
                                r_flush <= 1'b1;
                                r_left  <= r_fill + 1'b1;
                                r_state <= S_PUSH0;
                            end
                        end
                    end
                end
                S_PUSH0: begin
                    r_left  <= r_left - 1'b1;
                    r_end   <= (r_left == FILL_W'(1));
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_state <= S_CALC;
                end
                S_CALC: begin
                    if (s_mac_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (s_slot_free) begin
                        r_m_tvalid <= 1'b1;
                        r_m_tlast  <= r_end;
                        r_real     <= s_center;
                        r_imag     <= s_imag;
                        if (r_flush && r_left != '0) begin
                            r_state <= S_PUSH0;
                        end else begin
                            if (r_flush) begin
                                r_fill  <= '0;
                                r_flush <= 1'b0;
                            end
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tlast  = r_m_tlast;
    assign m_axis_tdata  = OUT_W'({r_imag, r_real});

endmodule

[src/fhas_checker.sv]
// port-level assertions for the hilbert analytic signal block and their bind
module fhas_checker import fhas_pkg::*; #(
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    parameter int IN_W         = 8 * ((SAMPLE_WIDTH + 7) / 8),
    parameter int OUT_W        = 8 * ((2 * SAMPLE_WIDTH + 7) / 8)
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic [IN_W-1:0]  s_axis_tdata,   // sample
    input logic             s_axis_tlast,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [OUT_W-1:0] m_axis_tdata,   // real_part, imag_part
    input logic             m_axis_tlast
);

    logic s_in_sample_seen;
    assign s_in_sample_seen = |s_axis_tdata || !s_axis_tdata[0];

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output item present right after reset");

    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && s_in_sample_seen
        |=> !s_axis_tready)
        else $error("input taken during flush of a run");

endmodule

bind fir_hilbert_analytic_signal fhas_checker #(
    .SAMPLE_WIDTH(SAMPLE_WIDTH),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
) u_fhas_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
